@@ rtl/tiled_palette_icon_decoder_core_assert.svh @@
// Assertion macros used by the decoder core.
`ifndef TILED_PALETTE_ICON_DECODER_CORE_ASSERT_SVH
`define TILED_PALETTE_ICON_DECODER_CORE_ASSERT_SVH

// Whenever cond holds, prop must hold in the same cycle.
`define TPID_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tpid assertion failed in the same cycle");

// Whenever cond holds, prop must hold in the next cycle.
`define TPID_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("tpid assertion failed one cycle later");

`endif

@@ rtl/tpid_pkg.sv @@
package tpid_pkg;

    localparam int PALETTE_SIZE = 16;
    localparam int ICON_PIXELS  = 1024;
    localparam int PAL_BYTES    = PALETTE_SIZE * 2;
    localparam int PIX_BYTES    = ICON_PIXELS / 2;
    localparam int TOTAL_BYTES  = PAL_BYTES + PIX_BYTES;

    localparam int COUNT_W      = 10;
    localparam int INDEX_W      = 11;
    localparam int COLOR_W      = 16;
    localparam int BYTE_W       = 8;
    localparam int NIBBLE_W     = 4;
    localparam int PAL_ADDR_W   = $clog2(PALETTE_SIZE);
    localparam int PIX_W        = $clog2(PIX_BYTES);

    localparam logic [INDEX_W-1:0] HEADER_OFFSET = INDEX_W'(2);

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [COLOR_W-1:0] color_t;

    // Pixel byte number (0..511) to the linear word index of its left pixel.
    // Two pixels per byte, so the pixel number is the byte number shifted by
    // one; tile row/column and in-tile row/column simply reorder its bits.
    function automatic logic [INDEX_W-1:0] tile_to_linear(input logic [PIX_W-1:0] k);
        logic [PIX_W:0]     pix;
        logic [1:0]         trow;
        logic [1:0]         tcol;
        logic [2:0]         yy;
        logic [2:0]         xx;
        logic [INDEX_W-2:0] lin;
        pix  = {k, 1'b0};
        trow = pix[9:8];
        tcol = pix[7:6];
        yy   = pix[5:3];
        xx   = pix[2:0];
        lin  = {trow, yy, tcol, xx};
        return {1'b0, lin} + HEADER_OFFSET;
    endfunction

endpackage

@@ rtl/tpid_ram.sv @@
module tpid_ram #(
    parameter int WIDTH = tpid_pkg::COLOR_W,
    parameter int DEPTH = tpid_pkg::PALETTE_SIZE
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // Read data holds while no read is issued.
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/tiled_palette_icon_decoder_core.sv @@
// Channel  | Handshake                | Payload
// ---------+--------------------------+-------------------------------------------------
// input    | in_valid / in_ready      | start_icon, in_byte
// output   | out_valid / out_ready    | dest_index, color_left, color_right,
//          |                          | trans_color, last
//
// One byte is taken per cycle while in_ready is high; a pixel byte's result is ready
// in the next cycle from the palette RAM's registered read port, the output register.
// Palette bytes and idle bytes give no result.
// in_ready drops only while a result waits and out_ready is low.
// rst_n is asynchronous; after reset the block is idle until a start mark.
module tiled_palette_icon_decoder_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           start_icon,
    input  logic [tpid_pkg::BYTE_W-1:0]    in_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tpid_pkg::INDEX_W-1:0]   dest_index,
    output logic [tpid_pkg::COLOR_W-1:0]   color_left,
    output logic [tpid_pkg::COLOR_W-1:0]   color_right,
    output logic [tpid_pkg::COLOR_W-1:0]   trans_color,
    output logic                           last
);

    localparam tpid_pkg::count_t CNT_TOTAL = tpid_pkg::COUNT_W'(tpid_pkg::TOTAL_BYTES);
    localparam tpid_pkg::count_t CNT_PAL   = tpid_pkg::COUNT_W'(tpid_pkg::PAL_BYTES);
    localparam tpid_pkg::count_t CNT_LAST  = tpid_pkg::COUNT_W'(tpid_pkg::TOTAL_BYTES - 1);

    tpid_pkg::count_t                  count_reg;
    tpid_pkg::count_t                  count_next;
    tpid_pkg::count_t                  count_eff;
    logic [tpid_pkg::BYTE_W-1:0]       low_hold_reg;
    logic [tpid_pkg::BYTE_W-1:0]       low_hold_next;
    tpid_pkg::color_t                  trans_reg;
    tpid_pkg::color_t                  trans_out_reg;
    logic [tpid_pkg::INDEX_W-1:0]      index_reg;
    logic                              last_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              in_accept;
    logic                              is_active;
    logic                              is_palette;
    logic                              is_pixel;
    logic                              pal_we;
    logic [tpid_pkg::PAL_ADDR_W-1:0]   pal_waddr;
    tpid_pkg::color_t                  pal_wdata;
    logic [tpid_pkg::PIX_W-1:0]        pix_num;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // A start mark restarts counting at the very byte that carries it.
    assign count_eff  = start_icon ? '0 : count_reg;
    assign is_active  = count_eff < CNT_TOTAL;
    assign is_palette = is_active && (count_eff < CNT_PAL);
    assign is_pixel   = is_active && !(count_eff < CNT_PAL);

    assign pal_we    = in_accept && is_palette && count_eff[0];
    assign pal_waddr = count_eff[tpid_pkg::PAL_ADDR_W:1];
    assign pal_wdata = {in_byte, low_hold_reg};

    // Byte count below 544 in the pixel phase, so the difference fits 9 bits.
    assign pix_num = tpid_pkg::PIX_W'(count_eff - CNT_PAL);

    always_comb
    begin
        count_next     = count_reg;
        low_hold_next  = low_hold_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_accept)
        begin
            if (is_active)
            begin
                count_next = count_eff + tpid_pkg::COUNT_W'(1);
            end
            else
            begin
                count_next = CNT_TOTAL;
            end
            if (is_palette && !count_eff[0])
            begin
                low_hold_next = in_byte;
            end
            if (is_pixel)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CNT_TOTAL;
            low_hold_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            low_hold_reg  <= low_hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers; entry 0 is mirrored so it can be read every cycle.
    always_ff @(posedge clk)
    begin
        if (pal_we && (pal_waddr == '0))
        begin
            trans_reg <= pal_wdata;
        end
        if (in_accept && is_pixel)
        begin
            index_reg     <= tpid_pkg::tile_to_linear(pix_num);
            last_reg      <= (count_eff == CNT_LAST);
            trans_out_reg <= trans_reg;
        end
    end

    tpid_ram #(
        .WIDTH (tpid_pkg::COLOR_W),
        .DEPTH (tpid_pkg::PALETTE_SIZE)
    ) u_palette (
        .clk     (clk),
        .we      (pal_we),
        .waddr   (pal_waddr),
        .wdata   (pal_wdata),
        .re      (in_accept && is_pixel),
        .raddr_a (in_byte[tpid_pkg::NIBBLE_W-1:0]),
        .raddr_b (in_byte[tpid_pkg::BYTE_W-1:tpid_pkg::NIBBLE_W]),
        .rdata_a (color_left),
        .rdata_b (color_right)
    );

    assign out_valid   = out_valid_reg;
    assign dest_index  = index_reg;
    assign trans_color = trans_out_reg;
    assign last        = last_reg;

`include "tiled_palette_icon_decoder_core_assert.svh"

    `TPID_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_TOTAL)
    `TPID_ASSERT_NEXT(a_pixel_gives_result, clk, rst_n, in_accept && is_pixel, out_valid_reg)
    `TPID_ASSERT_NEXT(a_last_goes_idle, clk, rst_n, in_accept && is_pixel && (count_eff == CNT_LAST), (count_reg == CNT_TOTAL) && last_reg)
    `TPID_ASSERT_SAME(a_no_write_with_read, clk, rst_n, pal_we, !(in_accept && is_pixel))

endmodule

@@ test/tpid_pixel_checker.sv @@
module tpid_pixel_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         start_icon,
    input  logic [tpid_pkg::BYTE_W-1:0]  in_byte,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [tpid_pkg::INDEX_W-1:0] dest_index,
    input  tpid_pkg::color_t             color_left,
    input  tpid_pkg::color_t             color_right,
    input  tpid_pkg::color_t             trans_color,
    input  logic                         last,
    output int                           mismatches,
    output int                           pairs_waiting
);
    import tpid_pkg::*;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        color_t             left;
        color_t             right;
        color_t             trans;
        logic               is_last;
    } pixel_pair_t;

    pixel_pair_t       pending_pairs[$];
    color_t            palette[PALETTE_SIZE];
    int unsigned       byte_pos;
    logic [BYTE_W-1:0] low_half;

    // Word index of the left pixel of pixel byte k in the linear 32-wide image.
    function automatic logic [INDEX_W-1:0] word_index(input int unsigned k);
        int unsigned px;
        int unsigned row;
        int unsigned col;
        px = 2 * k;
        // A tile holds 64 pixels; a band of four tiles covers eight image rows.
        row = (px / 256) * 8 + (px / 8) % 8;
        col = ((px / 64) % 4) * 8 + px % 8;
        return INDEX_W'(row * 32 + col + 2);
    endfunction

    task automatic report_mismatch(input string what, input logic [COLOR_W-1:0] got,
                                   input logic [COLOR_W-1:0] want);
        $display("checker: %s got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_pair_t want;
        if (!rst_n)
        begin
            pending_pairs.delete();
            byte_pos      = TOTAL_BYTES;
            low_half      = '0;
            pairs_waiting = 0;
            foreach (palette[i])
                palette[i] = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_pairs.size() == 0)
                    report_mismatch("result with no request waiting, dest_index",
                                    COLOR_W'(dest_index), '0);
                else
                begin
                    want = pending_pairs.pop_front();
                    if (dest_index !== want.index)
                        report_mismatch("dest_index", COLOR_W'(dest_index),
                                        COLOR_W'(want.index));
                    if (color_left !== want.left)
                        report_mismatch("color_left", color_left, want.left);
                    if (color_right !== want.right)
                        report_mismatch("color_right", color_right, want.right);
                    if (trans_color !== want.trans)
                        report_mismatch("trans_color", trans_color, want.trans);
                    if (last !== want.is_last)
                        report_mismatch("last", COLOR_W'(last), COLOR_W'(want.is_last));
                end
            end
            if (in_valid && in_ready)
            begin
                if (start_icon)
                    byte_pos = 0;
                if (byte_pos >= TOTAL_BYTES)
                    byte_pos = TOTAL_BYTES;
                else if (byte_pos < PAL_BYTES)
                begin
                    if (byte_pos % 2 == 0)
                        low_half = in_byte;
                    else
                        palette[byte_pos / 2] = {in_byte, low_half};
                    byte_pos++;
                end
                else
                begin
                    want.index   = word_index(byte_pos - PAL_BYTES);
                    want.left    = palette[in_byte[3:0]];
                    want.right   = palette[in_byte[7:4]];
                    want.trans   = palette[0];
                    want.is_last = (byte_pos == TOTAL_BYTES - 1);
                    pending_pairs.push_back(want);
                    byte_pos++;
                end
            end
            pairs_waiting = pending_pairs.size();
        end
    end

endmodule

@@ test/tb.sv @@
module tb;
    import tpid_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 450;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               start_icon = 1'b0;
    logic [BYTE_W-1:0]  in_byte    = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [INDEX_W-1:0] dest_index;
    color_t             color_left;
    color_t             color_right;
    color_t             trans_color;
    logic               last;

    int          mismatches;
    int          pairs_waiting;
    int          src_idle     = 37;
    int          sink_idle    = 84;
    int          phase        = 0;
    int unsigned cycles       = 0;
    int unsigned stream_pos   = TOTAL_BYTES;
    int          decoded_bytes = 0;

    tiled_palette_icon_decoder_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_icon  (start_icon),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dest_index  (dest_index),
        .color_left  (color_left),
        .color_right (color_right),
        .trans_color (trans_color),
        .last        (last)
    );

    tpid_pixel_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_icon    (start_icon),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dest_index    (dest_index),
        .color_left    (color_left),
        .color_right   (color_right),
        .trans_color   (trans_color),
        .last          (last),
        .mismatches    (mismatches),
        .pairs_waiting (pairs_waiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= sink_idle);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pairs_waiting != 0)
            @(negedge clk);
    endtask

    // The idle pattern may change between any two requests, even inside an icon.
    task automatic advance_phase();
        if (phase == 0 && decoded_bytes >= 150)
        begin
            wait_drained();
            phase     = 1;
            src_idle  = 84;
            sink_idle = 37;
        end
        else if (phase == 1 && decoded_bytes >= 300)
        begin
            wait_drained();
            phase     = 2;
            src_idle  = 0;
            sink_idle = 0;
        end
    endtask

    // Entered and left at a falling edge; the request is held until accepted.
    task automatic send_byte(input logic st, input logic [BYTE_W-1:0] b);
        advance_phase();
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        start_icon <= st;
        in_byte    <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (st)
            stream_pos = 0;
        if (stream_pos < TOTAL_BYTES)
        begin
            stream_pos++;
            decoded_bytes++;
        end
        @(negedge clk);
    endtask

    task automatic send_icon(input int pal_bytes, input int pix_bytes);
        for (int i = 0; i < pal_bytes + pix_bytes; i++)
            send_byte(i == 0, rand_byte());
    endtask

    initial
    begin
        bit icon_done;
        int pick;
        int n;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Bytes before any start mark are dropped.
        send_byte(1'b0, 8'hA5);
        send_byte(1'b0, 8'h5A);
        // A palette cut short by a new start mark.
        send_byte(1'b1, 8'h12);
        send_byte(1'b0, 8'h34);
        send_byte(1'b0, 8'h56);
        // Full palette: entry 0 all zeros, entry 15 all ones.
        send_byte(1'b1, 8'h00);
        send_byte(1'b0, 8'h00);
        for (int e = 1; e < PALETTE_SIZE - 1; e++)
        begin
            send_byte(1'b0, {4'(e), ~4'(e)});
            send_byte(1'b0, {~4'(e), 4'(e)});
        end
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h0F);
        send_byte(1'b0, 8'hF0);

        decoded_bytes = 0;
        icon_done = 1'b0;
        while (decoded_bytes < RANDOM_ITEMS || !icon_done)
        begin
            pick = $urandom_range(99);
            if (pick < 20 || (decoded_bytes >= 380 && !icon_done))
            begin
                // Whole icon, then up to three bytes that must be dropped.
                send_icon(PAL_BYTES, PIX_BYTES + $urandom_range(3));
                icon_done = 1'b1;
            end
            else if (pick < 60)
                send_icon(PAL_BYTES, $urandom_range(1, 120));
            else if (pick < 80)
                send_icon($urandom_range(1, PAL_BYTES - 1), 0);
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(1'b0, rand_byte());
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pairs_waiting == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
